// File: src/asas_pkg.sv
// Shared types, codes and constants for the accelerometer self-test and averaging sequencer.
package asas_pkg;

  localparam int BATCH_LOG2 = 5;
  localparam int SMP_W      = 16;
  localparam int SUM_W      = SMP_W + BATCH_LOG2;
  localparam int OFS_W      = SMP_W + 1;

  typedef logic signed [SMP_W-1:0] smp_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [OFS_W-1:0] ofs_t;
  typedef logic [BATCH_LOG2-1:0]   cnt_t;

  localparam logic [2:0] REQ_TICK   = 3'd0;
  localparam logic [2:0] REQ_ID     = 3'd1;
  localparam logic [2:0] REQ_SAMPLE = 3'd2;
  localparam logic [2:0] REQ_LINK   = 3'd3;
  localparam logic [2:0] REQ_ZERO   = 3'd4;
  localparam logic [2:0] REQ_UNZERO = 3'd5;

  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_CONFIG  = 3'd1;
  localparam logic [2:0] ACT_ST_ON   = 3'd2;
  localparam logic [2:0] ACT_REARM   = 3'd3;
  localparam logic [2:0] ACT_RESTORE = 3'd4;

  localparam logic [2:0] PH_STARTUP  = 3'd0;
  localparam logic [2:0] PH_BASELINE = 3'd1;
  localparam logic [2:0] PH_SETTLE   = 3'd2;
  localparam logic [2:0] PH_SELFTEST = 3'd3;
  localparam logic [2:0] PH_MEASURE  = 3'd4;
  localparam logic [2:0] PH_ERROR    = 3'd5;

  localparam logic [2:0] FLT_NONE     = 3'd0;
  localparam logic [2:0] FLT_START_TO = 3'd1;
  localparam logic [2:0] FLT_LINK     = 3'd2;
  localparam logic [2:0] FLT_BATCH_TO = 3'd3;
  localparam logic [2:0] FLT_WINDOW   = 3'd4;

  localparam logic [1:0] CFG_EXP_ID  = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_SETTLE  = 2'd2;

  localparam logic [7:0]  EXP_ID_RST  = 8'd229;
  localparam logic [15:0] TIMEOUT_RST = 16'd1000;
  localparam logic [7:0]  SETTLE_RST  = 8'd25;

  localparam ofs_t ST_LO [3] = '{17'sd85, -17'sd949, 17'sd118};
  localparam ofs_t ST_HI [3] = '{17'sd949, -17'sd85, 17'sd1294};

endpackage

// File: src/accel_selftest_average_sequencer_unit.sv
// Top level of the accelerometer self-test and block-averaging sequencer.
// Usage:
//   Input words (in_valid/in_stall) carry one request: tick, id byte, sample,
//   link error, zero down or cancel zero. Every input word yields exactly one
//   result word (out_valid/out_stall) with the action, mode, sticky fault,
//   averaged axes and change flags after that request.
//   A word is taken in an input register, processed by single-pass logic
//   that updates the sequencer state, and lands in the output register,
//   from which out_valid presents it to the receiver.
//   Throughput is one word per cycle; only out_stall slows it down.
//   When the receiver holds out_stall, the output word is kept stable, the
//   input register holds its word and in_stall rises while it is full.
//   Reset (rst_n low, synchronous) returns to startup mode, loads the
//   registers with their defaults and the timer with run_timeout_ms.
//   The cfg port writes expected_id (0), run_timeout_ms (1), settle_ms (2);
//   timeout and settle writes take effect the next time the timer is loaded.
module accel_selftest_average_sequencer_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [15:0]               cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                in_req_type,
  input  logic [7:0]                in_id_value,
  input  asas_pkg::smp_t            in_sample_x,
  input  asas_pkg::smp_t            in_sample_y,
  input  asas_pkg::smp_t            in_sample_z,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [2:0]                out_action,
  output logic [2:0]                out_mode,
  output logic [2:0]                out_fault,
  output logic                      out_new_result,
  output asas_pkg::ofs_t            out_out_x,
  output asas_pkg::ofs_t            out_out_y,
  output asas_pkg::smp_t            out_out_z,
  output logic                      out_changed_x,
  output logic                      out_changed_y,
  output logic                      out_changed_z
);
  import asas_pkg::*;

  logic [7:0]  exp_id_r;
  logic [15:0] timeout_r;
  logic [7:0]  settle_r;

  logic        s1_valid_r;
  logic [2:0]  s1_req_r;
  logic [7:0]  s1_id_r;
  smp_t        s1_smp_r [3];

  logic [2:0]  phase_r, phase_nxt;
  logic [2:0]  fault_r, fault_nxt;
  logic [15:0] tmr_r, tmr_nxt;
  cnt_t        cnt_r, cnt_nxt;
  sum_t        sum_r [3];
  sum_t        sum_nxt [3];
  smp_t        base_r [3];
  smp_t        base_nxt [3];
  smp_t        lat_r [3];
  smp_t        lat_nxt [3];
  smp_t        prev_r [3];
  smp_t        prev_nxt [3];
  ofs_t        zofs_r [2];
  ofs_t        zofs_nxt [2];

  logic        out_valid_r;
  logic [2:0]  action_r;
  logic [2:0]  mode_r;
  logic [2:0]  fault_o_r;
  logic        newr_r;
  ofs_t        ox_r, oy_r;
  smp_t        oz_r;
  logic [2:0]  chg_r;

  logic        adv, in_fire, step;
  logic [2:0]  action_nxt;
  logic        newr_nxt;
  logic [2:0]  chg_nxt;
  sum_t        sum_add [3];
  smp_t        avg [3];
  ofs_t        delta [3];
  logic        st_ok;
  logic [15:0] tmr_dec;
  logic        batch_done;
  logic        in_batch;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv;
  assign in_fire  = in_valid && !in_stall;
  assign step     = s1_valid_r && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_id_r  <= EXP_ID_RST;
      timeout_r <= TIMEOUT_RST;
      settle_r  <= SETTLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EXP_ID:  exp_id_r  <= cfg_wdata[7:0];
        CFG_TIMEOUT: timeout_r <= cfg_wdata;
        CFG_SETTLE:  settle_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire || (s1_valid_r && !adv);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r    <= in_req_type;
      s1_id_r     <= in_id_value;
      s1_smp_r[0] <= in_sample_x;
      s1_smp_r[1] <= in_sample_y;
      s1_smp_r[2] <= in_sample_z;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    fault_nxt  = fault_r;
    tmr_nxt    = tmr_r;
    cnt_nxt    = cnt_r;
    action_nxt = ACT_NONE;
    newr_nxt   = 1'b0;
    chg_nxt    = '0;
    for (int a = 0; a < 3; a++) begin
      sum_nxt[a]  = sum_r[a];
      base_nxt[a] = base_r[a];
      lat_nxt[a]  = lat_r[a];
      prev_nxt[a] = prev_r[a];
      sum_add[a]  = sum_r[a] + SUM_W'(s1_smp_r[a]);
      avg[a]      = sum_add[a][SUM_W-1:BATCH_LOG2];
      delta[a]    = OFS_W'(avg[a]) - OFS_W'(base_r[a]);
    end
    for (int a = 0; a < 2; a++) begin
      zofs_nxt[a] = zofs_r[a];
    end
    st_ok = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if (delta[a] <= ST_LO[a] || delta[a] >= ST_HI[a]) begin
        st_ok = 1'b0;
      end
    end
    tmr_dec    = (tmr_r != '0) ? tmr_r - 16'd1 : '0;
    batch_done = (cnt_r == '1);
    in_batch   = (phase_r == PH_BASELINE) || (phase_r == PH_SELFTEST) ||
                 (phase_r == PH_MEASURE);

    unique case (s1_req_r)
      REQ_TICK: begin
        if (phase_r != PH_ERROR) begin
          tmr_nxt = tmr_dec;
          if (tmr_dec == '0) begin
            priority if (phase_r == PH_STARTUP) begin
              phase_nxt = PH_ERROR;
              fault_nxt = FLT_START_TO;
            end else if (phase_r == PH_SETTLE) begin
              action_nxt = ACT_REARM;
              phase_nxt  = PH_SELFTEST;
              tmr_nxt    = timeout_r;
              cnt_nxt    = '0;
              for (int a = 0; a < 3; a++) sum_nxt[a] = '0;
            end else begin
              phase_nxt = PH_ERROR;
              fault_nxt = FLT_BATCH_TO;
            end
          end
        end
      end
      REQ_ID: begin
        if (phase_r == PH_STARTUP && s1_id_r == exp_id_r) begin
          action_nxt = ACT_CONFIG;
          phase_nxt  = PH_BASELINE;
          tmr_nxt    = timeout_r;
          cnt_nxt    = '0;
          for (int a = 0; a < 3; a++) sum_nxt[a] = '0;
        end
      end
      REQ_SAMPLE: begin
        if (in_batch) begin
          cnt_nxt = cnt_r + cnt_t'(1);
          for (int a = 0; a < 3; a++) sum_nxt[a] = sum_add[a];
          if (batch_done) begin
            cnt_nxt = '0;
            for (int a = 0; a < 3; a++) sum_nxt[a] = '0;
            priority if (phase_r == PH_BASELINE) begin
              for (int a = 0; a < 3; a++) begin
                base_nxt[a] = avg[a];
                lat_nxt[a]  = avg[a];
              end
              action_nxt = ACT_ST_ON;
              tmr_nxt    = {8'd0, settle_r};
              phase_nxt  = PH_SETTLE;
            end else if (phase_r == PH_SELFTEST) begin
              if (st_ok) begin
                action_nxt = ACT_RESTORE;
                tmr_nxt    = timeout_r;
                phase_nxt  = PH_MEASURE;
              end else begin
                phase_nxt = PH_ERROR;
                fault_nxt = FLT_WINDOW;
              end
            end else begin
              tmr_nxt = timeout_r;
              for (int a = 0; a < 3; a++) begin
                lat_nxt[a]  = avg[a];
                chg_nxt[a]  = (avg[a] != prev_r[a]);
                prev_nxt[a] = avg[a];
              end
              newr_nxt = 1'b1;
            end
          end
        end
      end
      REQ_LINK: begin
        if (phase_r != PH_ERROR) begin
          phase_nxt = PH_ERROR;
          fault_nxt = FLT_LINK;
        end
      end
      REQ_ZERO: begin
        for (int a = 0; a < 2; a++) zofs_nxt[a] = -OFS_W'(lat_r[a]);
      end
      REQ_UNZERO: begin
        for (int a = 0; a < 2; a++) zofs_nxt[a] = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_STARTUP;
      fault_r <= FLT_NONE;
      tmr_r   <= TIMEOUT_RST;
      cnt_r   <= '0;
      for (int a = 0; a < 3; a++) begin
        sum_r[a]  <= '0;
        base_r[a] <= '0;
        lat_r[a]  <= '0;
        prev_r[a] <= '0;
      end
      for (int a = 0; a < 2; a++) zofs_r[a] <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      fault_r <= fault_nxt;
      tmr_r   <= tmr_nxt;
      cnt_r   <= cnt_nxt;
      for (int a = 0; a < 3; a++) begin
        sum_r[a]  <= sum_nxt[a];
        base_r[a] <= base_nxt[a];
        lat_r[a]  <= lat_nxt[a];
        prev_r[a] <= prev_nxt[a];
      end
      for (int a = 0; a < 2; a++) zofs_r[a] <= zofs_nxt[a];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      action_r  <= action_nxt;
      mode_r    <= phase_nxt;
      fault_o_r <= fault_nxt;
      newr_r    <= newr_nxt;
      ox_r      <= OFS_W'(lat_nxt[0]) + zofs_nxt[0];
      oy_r      <= OFS_W'(lat_nxt[1]) + zofs_nxt[1];
      oz_r      <= lat_nxt[2];
      chg_r     <= chg_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_action     = action_r;
  assign out_mode       = mode_r;
  assign out_fault      = fault_o_r;
  assign out_new_result = newr_r;
  assign out_out_x      = ox_r;
  assign out_out_y      = oy_r;
  assign out_out_z      = oz_r;
  assign out_changed_x  = chg_r[0];
  assign out_changed_y  = chg_r[1];
  assign out_changed_z  = chg_r[2];

endmodule

// File: src/asas_checker.sv
// Port-level checker for the sequencer result channel, bound to the top level.
module asas_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_action,
  input logic [2:0] out_mode,
  input logic [2:0] out_fault,
  input logic       out_new_result,
  input logic       out_changed_x,
  input logic       out_changed_y,
  input logic       out_changed_z
);
  import asas_pkg::*;

  logic err_seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_seen_r <= 1'b0;
    end else if (out_valid && !out_stall && out_mode == PH_ERROR) begin
      err_seen_r <= 1'b1;
    end
  end

  // error mode is sticky across delivered words
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && err_seen_r |-> out_mode == PH_ERROR && out_fault != FLT_NONE)
    else $error("error mode left");

  a_fault_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_fault != FLT_NONE) == (out_mode == PH_ERROR)))
    else $error("fault code and mode disagree");

  a_new_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_new_result || out_action == ACT_RESTORE) |-> out_mode == PH_MEASURE)
    else $error("measurement word outside measuring mode");

  a_changed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_changed_x || out_changed_y || out_changed_z) |-> out_new_result)
    else $error("change flag without new result");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_mode) && $stable(out_action))
    else $error("stalled word changed");

endmodule

bind accel_selftest_average_sequencer_unit asas_checker u_asas_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_action     (out_action),
  .out_mode       (out_mode),
  .out_fault      (out_fault),
  .out_new_result (out_new_result),
  .out_changed_x  (out_changed_x),
  .out_changed_y  (out_changed_y),
  .out_changed_z  (out_changed_z)
);
